// ===== rtl/rrdsa_pkg.sv =====
// Package for the round-robin device send arbiter.
// Holds command and status codes, sequencer states and default sizes.
// No dependencies.
`timescale 1ns / 1ps

package rrdsa_pkg;

	// Default table depth and stored key width
	localparam int MAX_DEVICES_DEF = 16;
	localparam int KEY_WIDTH_DEF   = 8;

	// Fixed field widths of the channels
	localparam int KEY_PORT_W = 8;
	localparam int ID_W       = 16;
	localparam int REQ_W      = 8;
	localparam int SIZE_W     = 16;

	// Packets of this many bytes or fewer are dropped
	localparam logic [SIZE_W-1:0] MIN_ROUTE_LEN = SIZE_W'(4);
	// Pending request count saturates here
	localparam logic [REQ_W-1:0]  REQ_MAX       = '1;

	typedef enum logic [2:0] {
		OP_ADD     = 3'd0,
		OP_REMOVE  = 3'd1,
		OP_REQUEST = 3'd2,
		OP_ENABLE  = 3'd3,
		OP_TIMEOUT = 3'd4,
		OP_SEND    = 3'd5,
		OP_ROUTE   = 3'd6
	} op_t;

	typedef enum logic [2:0] {
		STAT_OK        = 3'd0,
		STAT_DUPLICATE = 3'd1,
		STAT_NOT_FOUND = 3'd2,
		STAT_FULL      = 3'd3,
		STAT_NO_GRANT  = 3'd4,
		STAT_SHORT     = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_ACT,
		S_SHIFT,
		S_FIN
	} state_t;

endpackage

// ===== rtl/rrdsa_req_if.sv =====
// Request channel of the round-robin device send arbiter.
// Carries valid, ready and one command item. No dependencies.
`timescale 1ns / 1ps

interface rrdsa_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  req_type;
	logic [7:0]  device_key;
	logic [15:0] dev_id;
	logic        enable;
	logic [15:0] packet_size;

	modport source (output valid, req_type, device_key, dev_id, enable, packet_size,
		input ready);
	modport sink (input valid, req_type, device_key, dev_id, enable, packet_size,
		output ready);
endinterface

// ===== rtl/rrdsa_rsp_if.sv =====
// Response channel of the round-robin device send arbiter.
// Carries valid, ready and one result item. No dependencies.
`timescale 1ns / 1ps

interface rrdsa_rsp_if;
	logic       valid;
	logic       ready;
	logic [2:0] status;
	logic       grant_valid;
	logic [7:0] grant_key;
	logic       route_valid;
	logic [7:0] route_key;

	modport source (output valid, status, grant_valid, grant_key, route_valid, route_key,
		input ready);
	modport sink (input valid, status, grant_valid, grant_key, route_valid, route_key,
		output ready);
endinterface

// ===== rtl/rrdsa_mem.sv =====
// Device table memory: one write port, one read port, registered read data.
// No dependencies.
`timescale 1ns / 1ps

module rrdsa_mem #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data
);
	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// read port, registered read data
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end
endmodule

// ===== rtl/round_robin_device_send_arbiter.sv =====
// Round-robin device send arbiter: top level, command sequencer and table control.
// Depends on rrdsa_pkg, rrdsa_req_if, rrdsa_rsp_if and rrdsa_mem.
//
//   channel | dir | handshake   | item
//   req     | in  | valid/ready | req_type, device_key, dev_id, enable, packet_size
//   rsp     | out | valid/ready | status, grant_valid, grant_key, route_valid, route_key
//
// One item at a time. An item is accepted, then the table is scanned (one memory read
// per cycle through the single read port), then acted on, then compacted on a remove,
// and then the result is loaded.
// Reset clears count, round-robin position, enable and timeout flag; the table
// memory is not cleared since only slots below the count are read.
// A stalled result holds in the output register; the next item is taken once the
// result has moved there.
`timescale 1ns / 1ps

module round_robin_device_send_arbiter #(
	parameter int MAX_DEVICES = rrdsa_pkg::MAX_DEVICES_DEF,
	parameter int KEY_WIDTH   = rrdsa_pkg::KEY_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	rrdsa_req_if.sink   req,
	rrdsa_rsp_if.source rsp
);
	import rrdsa_pkg::*;

	localparam int AW = $clog2(MAX_DEVICES);
	localparam int CW = $clog2(MAX_DEVICES + 1);
	localparam int KS = (KEY_WIDTH < KEY_PORT_W) ? KEY_WIDTH : KEY_PORT_W;
	localparam int EW = KS + ID_W + REQ_W;

	state_t state_q, state_d;

	// item fields
	op_t             op_q;
	logic [KS-1:0]   key_q;
	logic [ID_W-1:0] id_q;

	// arbiter state
	logic [CW-1:0] count_q;
	logic [AW-1:0] rr_q;
	logic          enabled_q;
	logic          awaiting_q;

	// read sequencer
	logic [AW-1:0] ptr_q;
	logic [CW-1:0] left_q;
	logic          vld_s1;
	logic          last_s1;
	logic [AW-1:0] addr_s1;
	logic [EW-1:0] rd_data_s1;

	// scan result
	logic          found_q;
	logic [AW-1:0] hit_idx_q;
	logic [EW-1:0] hit_data_q;

	// result being built and output register
	status_t       res_status_q;
	logic          res_gv_q;
	logic [KS-1:0] res_gkey_q;
	logic          res_rv_q;
	logic [KS-1:0] res_rkey_q;
	logic          out_vld_q;
	status_t       out_status_q;
	logic          out_gv_q;
	logic [KS-1:0] out_gkey_q;
	logic          out_rv_q;
	logic [KS-1:0] out_rkey_q;

	// memory ports
	logic          rd_en;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [EW-1:0] wr_data;

	logic          acc;
	op_t           op_in;
	logic          cnt_zero;
	logic [AW-1:0] last_idx;
	logic [AW-1:0] rr_after;
	logic [KS-1:0]    ent_key, hit_key;
	logic [ID_W-1:0]  ent_id, hit_id;
	logic [REQ_W-1:0] ent_req, hit_req;
	logic          key_op, hit, scan_end, out_load;
	logic          need_shift;
	state_t        launch_state;
	status_t       launch_status;

	rrdsa_mem #(
		.DEPTH (MAX_DEVICES),
		.WIDTH (EW)
	) u_mem (
		.clk     (clk),
		.rd_en   (rd_en),
		.rd_addr (ptr_q),
		.rd_data (rd_data_s1),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	// common decode
	assign acc      = req.valid && req.ready;
	assign op_in    = op_t'(req.req_type);
	assign cnt_zero = (count_q == '0);
	assign last_idx = AW'(count_q - CW'(1));
	assign rr_after = (rr_q == last_idx) ? '0 : rr_q + AW'(1);
	assign out_load = (state_q == S_FIN) && (!out_vld_q || rsp.ready);

	assign ent_key = rd_data_s1[EW-1 -: KS];
	assign ent_id  = rd_data_s1[REQ_W +: ID_W];
	assign ent_req = rd_data_s1[REQ_W-1:0];
	assign hit_key = hit_data_q[EW-1 -: KS];
	assign hit_id  = hit_data_q[REQ_W +: ID_W];
	assign hit_req = hit_data_q[REQ_W-1:0];

	// match test on the entry that just came out of memory
	assign key_op = (op_q == OP_ADD) || (op_q == OP_REMOVE) || (op_q == OP_REQUEST);
	always_comb begin
		if (key_op) begin
			hit = vld_s1 && (ent_key == key_q);
		end else if (op_q == OP_ROUTE) begin
			hit = vld_s1 && (ent_id == id_q);
		end else begin
			hit = vld_s1 && (ent_req != '0);
		end
	end
	assign scan_end   = vld_s1 && (hit || last_s1);
	assign need_shift = (CW'(hit_idx_q) + CW'(1)) < count_q;

	// where a freshly accepted item goes first
	always_comb begin
		launch_state  = S_FIN;
		launch_status = STAT_OK;
		case (op_in)
			OP_ADD, OP_REMOVE, OP_REQUEST: begin
				launch_state = cnt_zero ? S_ACT : S_SCAN;
			end
			OP_ROUTE: begin
				if (req.packet_size <= MIN_ROUTE_LEN) begin
					launch_status = STAT_SHORT;
				end else begin
					launch_state = cnt_zero ? S_ACT : S_SCAN;
				end
			end
			OP_ENABLE: begin
				if (req.enable && !awaiting_q && !cnt_zero) begin
					launch_state = S_SCAN;
				end
			end
			OP_TIMEOUT: begin
				if (enabled_q && !cnt_zero) begin
					launch_state = S_SCAN;
				end
			end
			OP_SEND: begin
				if (enabled_q && !awaiting_q && !cnt_zero) begin
					launch_state = S_SCAN;
				end else begin
					launch_status = STAT_NO_GRANT;
				end
			end
			default: begin
				launch_state = S_FIN;
			end
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:  if (acc) state_d = launch_state;
			S_SCAN:  if (scan_end) state_d = S_ACT;
			S_ACT: begin
				if (op_q == OP_REMOVE && found_q && need_shift) begin
					state_d = S_SHIFT;
				end else begin
					state_d = S_FIN;
				end
			end
			S_SHIFT: if (vld_s1 && last_s1) state_d = S_FIN;
			S_FIN:   if (out_load) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// sequencer outputs: handshake and memory control
	always_comb begin
		req.ready = (state_q == S_IDLE);
		rd_en     = ((state_q == S_SCAN) || (state_q == S_SHIFT)) && (left_q != '0);
		wr_en     = 1'b0;
		wr_addr   = hit_idx_q;
		wr_data   = hit_data_q;
		unique case (state_q)
			S_ACT: begin
				case (op_q)
					OP_ADD: begin
						wr_en   = !found_q && (count_q != CW'(MAX_DEVICES));
						wr_addr = AW'(count_q);
						wr_data = {key_q, id_q, REQ_W'(0)};
					end
					OP_REQUEST: begin
						wr_en   = found_q;
						wr_data = {hit_key, hit_id,
							(hit_req == REQ_MAX) ? hit_req : hit_req + REQ_W'(1)};
					end
					OP_ENABLE, OP_TIMEOUT, OP_SEND: begin
						wr_en   = found_q;
						wr_data = {hit_key, hit_id, hit_req - REQ_W'(1)};
					end
					default: wr_en = 1'b0;
				endcase
			end
			S_SHIFT: begin
				// move each later entry down one slot
				wr_en   = vld_s1;
				wr_addr = addr_s1 - AW'(1);
				wr_data = rd_data_s1;
			end
			S_IDLE, S_SCAN, S_FIN: wr_en = 1'b0;
			default: wr_en = 1'b0;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			count_q    <= '0;
			rr_q       <= '0;
			enabled_q  <= 1'b0;
			awaiting_q <= 1'b0;
			vld_s1     <= 1'b0;
			out_vld_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			vld_s1  <= rd_en;

			if (acc && op_in == OP_ENABLE) begin
				enabled_q <= req.enable;
			end
			if (acc && op_in == OP_TIMEOUT) begin
				awaiting_q <= 1'b0;
			end

			if (state_q == S_ACT) begin
				unique case (op_q)
					OP_ADD: begin
						if (!found_q && count_q != CW'(MAX_DEVICES)) begin
							count_q <= count_q + CW'(1);
						end
					end
					OP_REMOVE: begin
						if (found_q) begin
							if (hit_idx_q <= rr_q && rr_q != '0) begin
								rr_q <= rr_q - AW'(1);
							end
							if (!need_shift) begin
								count_q <= count_q - CW'(1);
							end
						end
					end
					OP_ENABLE, OP_TIMEOUT, OP_SEND: begin
						if (found_q) begin
							rr_q       <= hit_idx_q;
							awaiting_q <= 1'b1;
						end
					end
					default: ;
				endcase
			end
			if (state_q == S_SHIFT && vld_s1 && last_s1) begin
				count_q <= count_q - CW'(1);
			end

			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		// read address stepping, wraps at the last used slot
		if (rd_en) begin
			ptr_q   <= (ptr_q == last_idx) ? '0 : ptr_q + AW'(1);
			left_q  <= left_q - CW'(1);
			last_s1 <= (left_q == CW'(1));
			addr_s1 <= ptr_q;
		end

		if (acc) begin
			op_q         <= op_in;
			key_q        <= KS'(req.device_key);
			id_q         <= req.dev_id;
			found_q      <= 1'b0;
			left_q       <= count_q;
			ptr_q        <= (op_in == OP_ENABLE || op_in == OP_TIMEOUT || op_in == OP_SEND)
				? rr_after : '0;
			res_status_q <= launch_status;
			res_gv_q     <= 1'b0;
			res_gkey_q   <= '0;
			res_rv_q     <= 1'b0;
			res_rkey_q   <= '0;
		end

		if (state_q == S_SCAN && hit) begin
			found_q    <= 1'b1;
			hit_idx_q  <= addr_s1;
			hit_data_q <= rd_data_s1;
		end

		if (state_q == S_ACT) begin
			case (op_q)
				OP_ADD: begin
					if (found_q) begin
						res_status_q <= STAT_DUPLICATE;
					end else if (count_q == CW'(MAX_DEVICES)) begin
						res_status_q <= STAT_FULL;
					end
				end
				OP_REMOVE: begin
					if (!found_q) begin
						res_status_q <= STAT_NOT_FOUND;
					end else if (need_shift) begin
						ptr_q  <= hit_idx_q + AW'(1);
						left_q <= count_q - CW'(1) - CW'(hit_idx_q);
					end
				end
				OP_REQUEST: begin
					if (!found_q) res_status_q <= STAT_NOT_FOUND;
				end
				OP_ROUTE: begin
					if (!found_q) begin
						res_status_q <= STAT_NOT_FOUND;
					end else begin
						res_rv_q   <= 1'b1;
						res_rkey_q <= hit_key;
					end
				end
				OP_ENABLE, OP_TIMEOUT, OP_SEND: begin
					if (found_q) begin
						res_gv_q   <= 1'b1;
						res_gkey_q <= hit_key;
					end else if (op_q == OP_SEND) begin
						res_status_q <= STAT_NO_GRANT;
					end
				end
				default: ;
			endcase
		end

		if (out_load) begin
			out_status_q <= res_status_q;
			out_gv_q     <= res_gv_q;
			out_gkey_q   <= res_gkey_q;
			out_rv_q     <= res_rv_q;
			out_rkey_q   <= res_rkey_q;
		end
	end

	assign rsp.valid       = out_vld_q;
	assign rsp.status      = out_status_q;
	assign rsp.grant_valid = out_gv_q;
	assign rsp.grant_key   = KEY_PORT_W'(out_gkey_q);
	assign rsp.route_valid = out_rv_q;
	assign rsp.route_key   = KEY_PORT_W'(out_rkey_q);

`ifndef SYNTHESIS
	// table never holds more entries than its depth
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_DEVICES))
		else $error("entry count above table depth");

	// round-robin position stays inside the used part of the table
	a_rr_range: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != '0) |-> (CW'(rr_q) < count_q))
		else $error("round-robin position beyond last entry");

	// table is only written while an item is being worked on
	a_wr_busy: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> ((state_q == S_ACT) || (state_q == S_SHIFT)))
		else $error("table write outside act or shift");

	// a result load returns the sequencer to idle with the result held valid
	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> (state_q == S_IDLE) && out_vld_q)
		else $error("result load did not return sequencer to idle");
`endif
endmodule

// ===== tb/sv/round_robin_device_send_arbiter_tb.sv =====
// Testbench for the round-robin device send arbiter: directed table, then random traffic.
// Scoreboard predicts every result from its own table model and checks field by field.
// Depends on rrdsa_pkg, rrdsa_req_if, rrdsa_rsp_if and the arbiter RTL.
`timescale 1ns / 1ps

module round_robin_device_send_arbiter_tb;
	import rrdsa_pkg::*;

	localparam int DEPTH = 16;
	localparam int LIMIT = 600000;

	typedef struct packed {
		logic [2:0]  kind;
		logic [7:0]  dkey;
		logic [15:0] did;
		logic        en;
		logic [15:0] psize;
	} cmd_t;

	typedef struct packed {
		logic [2:0] status;
		logic       gvalid;
		logic [7:0] gkey;
		logic       rvalid;
		logic [7:0] rkey;
	} res_t;

	// directed row: command, whether the result is typed in, and that result
	typedef struct packed {
		cmd_t cmd;
		logic fixed;
		res_t res;
	} row_t;

	logic clk;
	logic arst_n;
	rrdsa_req_if req ();
	rrdsa_rsp_if rsp ();

	round_robin_device_send_arbiter u_top (
		.clk(clk), .arst_n(arst_n), .req(req.sink), .rsp(rsp.source)
	);

	// shadow copy of the device table
	logic [7:0]  tbl_key [DEPTH];
	logic [15:0] tbl_id [DEPTH];
	logic [7:0]  tbl_reqs [DEPTH];
	int          tbl_count;
	int          rr_pos;
	logic        chan_en;
	logic        wait_tmo;

	res_t pending_res [$];
	res_t typed_res [$];
	logic typed_flag [$];
	int   errors;
	int   n_grants;
	int   n_routes;
	int   cycles;
	int   send_idle_pct;
	int   recv_stall_pct;
	logic hold_recv;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > LIMIT) begin
				$display("timeout at %0t", $time);
				$display("FAIL");
				$finish;
			end
		end
	end

	function automatic int find_key(logic [7:0] k);
		for (int i = 0; i < tbl_count; i++)
			if (tbl_key[i] == k) return i;
		return -1;
	endfunction

	function automatic int find_id(logic [15:0] d);
		for (int i = 0; i < tbl_count; i++)
			if (tbl_id[i] == d) return i;
		return -1;
	endfunction

	// round-robin grant from the slot after rr_pos
	function automatic logic grant_next(output logic [7:0] k);
		int p;
		int j;
		k = '0;
		if (!chan_en || wait_tmo || tbl_count == 0) return 1'b0;
		p = rr_pos % tbl_count;
		for (int i = 1; i <= tbl_count; i++) begin
			j = (p + i) % tbl_count;
			if (tbl_reqs[j] != 0) begin
				rr_pos = j;
				tbl_reqs[j]--;
				wait_tmo = 1'b1;
				k = tbl_key[j];
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	function automatic res_t arbiter_predict(cmd_t c);
		res_t r;
		int idx;
		r = '0;
		case (c.kind)
			OP_ADD: begin
				if (find_key(c.dkey) >= 0) r.status = STAT_DUPLICATE;
				else if (tbl_count >= DEPTH) r.status = STAT_FULL;
				else begin
					tbl_key[tbl_count] = c.dkey;
					tbl_id[tbl_count] = c.did;
					tbl_reqs[tbl_count] = '0;
					tbl_count++;
				end
			end
			OP_REMOVE: begin
				idx = find_key(c.dkey);
				if (idx < 0) r.status = STAT_NOT_FOUND;
				else begin
					if (idx <= rr_pos && rr_pos > 0) rr_pos--;
					for (int i = idx; i + 1 < tbl_count; i++) begin
						tbl_key[i] = tbl_key[i+1];
						tbl_id[i] = tbl_id[i+1];
						tbl_reqs[i] = tbl_reqs[i+1];
					end
					tbl_count--;
				end
			end
			OP_REQUEST: begin
				idx = find_key(c.dkey);
				if (idx < 0) r.status = STAT_NOT_FOUND;
				else if (tbl_reqs[idx] != REQ_MAX) tbl_reqs[idx]++;
			end
			OP_ENABLE: begin
				chan_en = c.en;
				if (chan_en) r.gvalid = grant_next(r.gkey);
			end
			OP_TIMEOUT: begin
				wait_tmo = 1'b0;
				r.gvalid = grant_next(r.gkey);
			end
			OP_SEND: begin
				r.gvalid = grant_next(r.gkey);
				if (!r.gvalid) r.status = STAT_NO_GRANT;
			end
			OP_ROUTE: begin
				if (c.psize <= MIN_ROUTE_LEN) r.status = STAT_SHORT;
				else begin
					idx = find_id(c.did);
					if (idx < 0) r.status = STAT_NOT_FOUND;
					else begin
						r.rvalid = 1'b1;
						r.rkey = tbl_key[idx];
					end
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	// drive one item and wait for its acceptance; valid stays up for the next item
	task automatic send_cmd(cmd_t c, logic fixed, res_t fr);
		while ($urandom_range(99) < send_idle_pct) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid <= 1'b1;
		{req.req_type, req.device_key, req.dev_id, req.enable, req.packet_size} <= c;
		do @(posedge clk); while (!req.ready);
		pending_res.push_back(arbiter_predict(c));
		typed_flag.push_back(fixed);
		typed_res.push_back(fr);
	endtask

	function automatic cmd_t mk(logic [2:0] k, logic [7:0] dk, logic [15:0] d,
			logic e, logic [15:0] s);
		cmd_t c;
		c = {k, dk, d, e, s};
		return c;
	endfunction

	// random command; well-formed traffic mostly on a small key set
	function automatic cmd_t rand_cmd();
		cmd_t c;
		c.kind = 3'($urandom_range(6));
		if ($urandom_range(19) == 0) c.kind = 3'd7;
		c.dkey = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(19));
		c.did = ($urandom_range(4) == 0) ? 16'($urandom) : 16'($urandom_range(23));
		c.en = ($urandom_range(3) != 0);
		c.psize = ($urandom_range(3) == 0) ? 16'($urandom_range(6)) : 16'($urandom);
		if (c.kind == 3'd0 && $urandom_range(3) != 0) c.kind = OP_REQUEST;
		return c;
	endfunction

	// receiver: random stalls plus a long hold-off phase
	always @(posedge clk) begin
		if (hold_recv) rsp.ready <= 1'b0;
		else rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// check accepted results against the oldest expectation
	always @(posedge clk) begin
		res_t act;
		res_t exp_r;
		if (arst_n && rsp.valid && rsp.ready) begin
			act = {rsp.status, rsp.grant_valid, rsp.grant_key, rsp.route_valid, rsp.route_key};
			if (pending_res.size() == 0) begin
				$display("%0t: unexpected result %h", $time, act);
				errors++;
			end else begin
				exp_r = pending_res.pop_front();
				if (typed_flag.pop_front() && typed_res[0] != exp_r) begin
					$display("%0t: typed row %h disagrees with prediction %h",
						$time, typed_res[0], exp_r);
					errors++;
				end
				void'(typed_res.pop_front());
				if (act.status != exp_r.status || act.gvalid != exp_r.gvalid ||
						act.gkey != exp_r.gkey || act.rvalid != exp_r.rvalid ||
						act.rkey != exp_r.rkey) begin
					$display("%0t: mismatch expected %h actual %h", $time, exp_r, act);
					errors++;
				end
				if (act.gvalid) n_grants++;
				if (act.rvalid) n_routes++;
			end
		end
	end

	initial begin
		row_t rows [$];
		cmd_t c;
		int stall_cnt;
		errors = 0;
		n_grants = 0;
		n_routes = 0;
		tbl_count = 0;
		rr_pos = 0;
		chan_en = 1'b0;
		wait_tmo = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_recv = 1'b0;
		req.valid = 1'b0;
		{req.req_type, req.device_key, req.dev_id, req.enable, req.packet_size} = '0;
		rsp.ready = 1'b0;
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows; typed-in results only where obvious
		rows.push_back({mk(OP_SEND, 8'd0, 16'd0, 1'b0, 16'd0), 1'b1, res_t'({STAT_NO_GRANT, 18'd0})});
		rows.push_back({mk(OP_REMOVE, 8'hFF, 16'd0, 1'b0, 16'd0), 1'b1, res_t'({STAT_NOT_FOUND, 18'd0})});
		rows.push_back({mk(OP_ADD, 8'hFF, 16'hFFFF, 1'b0, 16'd0), 1'b1, res_t'({STAT_OK, 18'd0})});
		rows.push_back({mk(OP_ADD, 8'hFF, 16'd1, 1'b0, 16'd0), 1'b1, res_t'({STAT_DUPLICATE, 18'd0})});
		rows.push_back({mk(OP_ADD, 8'h00, 16'h0000, 1'b0, 16'd0), 1'b1, res_t'({STAT_OK, 18'd0})});
		rows.push_back({mk(OP_ROUTE, 8'd0, 16'hFFFF, 1'b0, 16'd4), 1'b1, res_t'({STAT_SHORT, 18'd0})});
		rows.push_back({mk(OP_ROUTE, 8'd0, 16'hFFFF, 1'b0, 16'hFFFF), 1'b1,
			res_t'({STAT_OK, 1'b0, 8'd0, 1'b1, 8'hFF})});
		rows.push_back({mk(OP_ROUTE, 8'd0, 16'h1234, 1'b0, 16'd5), 1'b1, res_t'({STAT_NOT_FOUND, 18'd0})});
		rows.push_back({mk(OP_REQUEST, 8'h00, 16'd0, 1'b0, 16'd0), 1'b0, res_t'(0)});
		rows.push_back({mk(OP_REQUEST, 8'hFF, 16'd0, 1'b0, 16'd0), 1'b0, res_t'(0)});
		rows.push_back({mk(OP_REQUEST, 8'h55, 16'd0, 1'b0, 16'd0), 1'b1, res_t'({STAT_NOT_FOUND, 18'd0})});
		rows.push_back({mk(OP_ENABLE, 8'd0, 16'd0, 1'b1, 16'd0), 1'b0, res_t'(0)});
		rows.push_back({mk(OP_SEND, 8'd0, 16'd0, 1'b0, 16'd0), 1'b0, res_t'(0)});
		rows.push_back({mk(OP_TIMEOUT, 8'd0, 16'd0, 1'b0, 16'd0), 1'b0, res_t'(0)});
		rows.push_back({mk(OP_ENABLE, 8'd0, 16'd0, 1'b0, 16'd0), 1'b0, res_t'(0)});
		rows.push_back({mk(OP_TIMEOUT, 8'd0, 16'd0, 1'b0, 16'd0), 1'b0, res_t'(0)});
		rows.push_back({mk(OP_REMOVE, 8'h00, 16'd0, 1'b0, 16'd0), 1'b0, res_t'(0)});
		rows.push_back({mk(3'd7, 8'hAA, 16'hAAAA, 1'b1, 16'hAAAA), 1'b1, res_t'({STAT_OK, 18'd0})});
		foreach (rows[i]) send_cmd(rows[i].cmd, rows[i].fixed, rows[i].res);

		// saturate one count and fill the table past full
		repeat (260) send_cmd(mk(OP_REQUEST, 8'hFF, 16'd0, 1'b0, 16'd0), 1'b0, res_t'(0));
		for (int k = 0; k < 17; k++)
			send_cmd(mk(OP_ADD, 8'(k + 1), 16'(k), 1'b0, 16'd0), 1'b0, res_t'(0));
		send_cmd(mk(OP_ENABLE, 8'd0, 16'd0, 1'b1, 16'd0), 1'b0, res_t'(0));

		// random phases with different idle and stall rates
		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 85; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 85; end
				3: begin send_idle_pct = 28; recv_stall_pct = 28; end
				default: begin send_idle_pct = 0; recv_stall_pct = 0; end
			endcase
			if (ph == 4) begin
				// long receiver hold-off while items keep coming
				fork
					begin
						hold_recv = 1'b1;
						stall_cnt = 0;
						while (stall_cnt < 300) begin
							@(posedge clk);
							stall_cnt++;
						end
						hold_recv = 1'b0;
					end
				join_none
			end
			repeat (32) begin
				c = rand_cmd();
				send_cmd(c, 1'b0, res_t'(0));
			end
		end
		req.valid <= 1'b0;

		// drain
		send_idle_pct = 0;
		recv_stall_pct = 0;
		while (pending_res.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		$display("covered directed edges, saturation, full table, 160 random items");
		$display("grants seen %0d, routes seen %0d, errors %0d", n_grants, n_routes, errors);
		if (errors == 0) $display("PASS");
		else $display("FAIL");
		$finish;
	end
endmodule
